// ===== sv/pws_pkg.sv =====
package pws_pkg;

  // command codes
  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_STOP   = 2'd1;
  localparam logic [1:0] CMD_WAKEUP = 2'd2;

  // pump result codes
  localparam logic [4:0] PC_WAITING        = 5'd0;
  localparam logic [4:0] PC_PROGRESS_FIRST = 5'd1;
  localparam logic [4:0] PC_PROGRESS_LAST  = 5'd6;
  localparam logic [4:0] PC_NOT_READY      = 5'd7;
  localparam logic [4:0] PC_END            = 5'd8;
  localparam logic [4:0] PC_READER_FAILED  = 5'd11;
  localparam logic [4:0] PC_INVALID_TIMING = 5'd14;
  localparam logic [4:0] PC_FATAL_LAST     = 5'd19;

  // driver states
  localparam logic [2:0] ST_STOPPED = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_ARMED   = 3'd2;
  localparam logic [2:0] ST_ENDED   = 3'd3;
  localparam logic [2:0] ST_FAILED  = 3'd4;

  // event status codes
  localparam logic [2:0] EV_ARMED_INITIAL = 3'd0;
  localparam logic [2:0] EV_IDLE          = 3'd1;
  localparam logic [2:0] EV_STALE         = 3'd2;
  localparam logic [2:0] EV_WAITING       = 3'd3;
  localparam logic [2:0] EV_REARMED       = 3'd4;
  localparam logic [2:0] EV_ENDED         = 3'd5;
  localparam logic [2:0] EV_FATAL         = 3'd6;

  // sink request kinds
  localparam logic [1:0] ARM_NONE      = 2'd0;
  localparam logic [1:0] ARM_IMMEDIATE = 2'd1;
  localparam logic [1:0] ARM_AT_TIME   = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] wakeup_token;
    logic [63:0] now_ns;
    logic        playing_before;
    logic [4:0]  pump_code;
    logic        due_valid;
    logic [63:0] due_ns;
    logic        playing_after;
    logic        sink_accepts;
  } pws_item_t;

  typedef struct packed {
    logic        running;
    logic        armed;
    logic [63:0] life_token;
    logic [2:0]  drv_state;
  } pws_state_t;

  typedef struct packed {
    logic [2:0]  event_status;
    logic [2:0]  driver_state;
    logic        pump_echo_valid;
    logic [4:0]  pump_echo;
    logic        next_due_valid;
    logic [63:0] next_due_ns;
    logic [63:0] token_out;
    logic [1:0]  arm_kind;
    logic [63:0] arm_time_ns;
    logic        disarm;
  } pws_result_t;

  // token advance; zero is never a live token
  function automatic logic [63:0] advance_token(input logic [63:0] tok);
    logic [63:0] inc;
    inc = tok + 64'd1;
    return (inc == 64'd0) ? 64'd1 : inc;
  endfunction

endpackage

// ===== sv/producer_wakeup_sequencer.sv =====
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_stall    cmd .. sink_accepts
// out       output     out_valid / out_stall  event_status .. disarm
// cfg       input      cfg_write              cfg_data (retry delay)
//
// One transaction per cycle sustained while out_stall is low; a command passes from the input
// register through the decision into the result register.
// The decision and state update happen together in the same cycle, so the next
// command sees the updated state with no bubble.
// Reset (rst, synchronous) clears the state, the retry delay and both valids.
// out_stall holds the result register and backs up into in_stall.
module producer_wakeup_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [63:0] wakeup_token,
  input  logic [63:0] now_ns,
  input  logic        playing_before,
  input  logic [4:0]  pump_code,
  input  logic        due_valid,
  input  logic [63:0] due_ns,
  input  logic        playing_after,
  input  logic        sink_accepts,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_status,
  output logic [2:0]  driver_state,
  output logic        pump_echo_valid,
  output logic [4:0]  pump_echo,
  output logic        next_due_valid,
  output logic [63:0] next_due_ns,
  output logic [63:0] token_out,
  output logic [1:0]  arm_kind,
  output logic [63:0] arm_time_ns,
  output logic        disarm
);

  logic [63:0]          not_ready_retry_ns;
  pws_pkg::pws_item_t   item;
  logic                 item_valid;
  pws_pkg::pws_state_t  state;
  pws_pkg::pws_state_t  state_next;
  pws_pkg::pws_result_t result_next;
  pws_pkg::pws_result_t result;
  logic                 out_free;
  logic                 advance;

  assign out_free = !out_valid || !out_stall;
  assign advance  = item_valid && out_free;
  assign in_stall = item_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      not_ready_retry_ns <= '0;
    end else if (cfg_write) begin
      not_ready_retry_ns <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.cmd            <= cmd;
      item.wakeup_token   <= wakeup_token;
      item.now_ns         <= now_ns;
      item.playing_before <= playing_before;
      item.pump_code      <= pump_code;
      item.due_valid      <= due_valid;
      item.due_ns         <= due_ns;
      item.playing_after  <= playing_after;
      item.sink_accepts   <= sink_accepts;
    end
  end

  pws_decide u_decide (
    .item       (item),
    .state      (state),
    .retry_ns   (not_ready_retry_ns),
    .state_next (state_next),
    .result     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.running    <= 1'b0;
      state.armed      <= 1'b0;
      state.life_token <= '0;
      state.drv_state  <= pws_pkg::ST_STOPPED;
      out_valid        <= 1'b0;
    end else begin
      if (advance) begin
        state <= state_next;
      end
      if (out_free) begin
        out_valid <= item_valid;
      end
    end
  end

  // result register; hold while stalled
  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign event_status    = result.event_status;
  assign driver_state    = result.driver_state;
  assign pump_echo_valid = result.pump_echo_valid;
  assign pump_echo       = result.pump_echo;
  assign next_due_valid  = result.next_due_valid;
  assign next_due_ns     = result.next_due_ns;
  assign token_out       = result.token_out;
  assign arm_kind        = result.arm_kind;
  assign arm_time_ns     = result.arm_time_ns;
  assign disarm          = result.disarm;

endmodule

// ===== sv/pws_decide.sv =====
module pws_decide (
  input  pws_pkg::pws_item_t   item,
  input  pws_pkg::pws_state_t  state,
  input  logic [63:0]          retry_ns,
  output pws_pkg::pws_state_t  state_next,
  output pws_pkg::pws_result_t result
);

  logic [64:0] retry_sum;
  logic        stale;
  logic        progressed;

  assign retry_sum  = {1'b0, item.now_ns} + {1'b0, retry_ns};
  assign stale      = (item.cmd != pws_pkg::CMD_WAKEUP) || !state.running || !state.armed ||
                      (item.wakeup_token != state.life_token);
  assign progressed = (item.pump_code >= pws_pkg::PC_PROGRESS_FIRST) &&
                      (item.pump_code <= pws_pkg::PC_PROGRESS_LAST);

  always_comb begin
    pws_pkg::pws_state_t s;
    logic [2:0]  status;
    logic        ev;
    logic [4:0]  echo;
    logic        dv;
    logic [63:0] due;
    logic [1:0]  kind;
    logic [63:0] atime;
    logic        disarm;
    logic        fatal;
    logic        shut;
    logic [2:0]  shut_state;

    s          = state;
    status     = pws_pkg::EV_STALE;
    ev         = 1'b0;
    echo       = '0;
    dv         = 1'b0;
    due        = '0;
    kind       = pws_pkg::ARM_NONE;
    atime      = '0;
    disarm     = 1'b0;
    fatal      = 1'b0;
    shut       = 1'b0;
    shut_state = pws_pkg::ST_FAILED;

    case (item.cmd)
      pws_pkg::CMD_START: begin
        if (!s.running) begin
          s.running    = 1'b1;
          s.life_token = pws_pkg::advance_token(s.life_token);
        end
        if (s.armed) begin
          status = pws_pkg::EV_ARMED_INITIAL;
        end else if (!item.playing_before) begin
          s.drv_state = pws_pkg::ST_IDLE;
          status      = pws_pkg::EV_IDLE;
        end else begin
          kind = pws_pkg::ARM_IMMEDIATE;
          if (item.sink_accepts) begin
            s.armed     = 1'b1;
            s.drv_state = pws_pkg::ST_ARMED;
            status      = pws_pkg::EV_ARMED_INITIAL;
          end else begin
            fatal = 1'b1;
          end
        end
      end
      pws_pkg::CMD_STOP: begin
        status = pws_pkg::EV_IDLE;
        if (s.running || (s.drv_state != pws_pkg::ST_STOPPED)) begin
          shut       = 1'b1;
          shut_state = pws_pkg::ST_STOPPED;
        end
      end
      default: begin
        if (!stale) begin
          s.armed = 1'b0;
          ev      = 1'b1;
          echo    = item.pump_code;
          if (!item.playing_before) begin
            ev          = 1'b0;
            echo        = '0;
            s.drv_state = pws_pkg::ST_IDLE;
            status      = pws_pkg::EV_IDLE;
          end else if (item.pump_code == pws_pkg::PC_WAITING) begin
            if (!item.due_valid) begin
              fatal = 1'b1;
              echo  = pws_pkg::PC_INVALID_TIMING;
            end else if (!item.playing_after) begin
              s.drv_state = pws_pkg::ST_IDLE;
              status      = pws_pkg::EV_IDLE;
            end else begin
              if (item.due_ns <= item.now_ns) begin
                kind = pws_pkg::ARM_IMMEDIATE;
              end else begin
                kind  = pws_pkg::ARM_AT_TIME;
                atime = item.due_ns;
              end
              if (item.sink_accepts) begin
                s.armed     = 1'b1;
                s.drv_state = pws_pkg::ST_ARMED;
                status      = pws_pkg::EV_WAITING;
                dv          = 1'b1;
                due         = item.due_ns;
              end else begin
                fatal = 1'b1;
              end
            end
          end else if (progressed) begin
            if (!item.playing_after) begin
              s.drv_state = pws_pkg::ST_IDLE;
              status      = pws_pkg::EV_IDLE;
            end else begin
              kind = pws_pkg::ARM_IMMEDIATE;
              if (item.sink_accepts) begin
                s.armed     = 1'b1;
                s.drv_state = pws_pkg::ST_ARMED;
                status      = pws_pkg::EV_REARMED;
              end else begin
                fatal = 1'b1;
              end
            end
          end else if (item.pump_code == pws_pkg::PC_NOT_READY) begin
            if (!item.playing_after || (retry_ns == 64'd0)) begin
              s.drv_state = pws_pkg::ST_IDLE;
              status      = pws_pkg::EV_IDLE;
            end else if (retry_sum[64]) begin
              fatal = 1'b1;
              echo  = pws_pkg::PC_INVALID_TIMING;
            end else begin
              kind  = pws_pkg::ARM_AT_TIME;
              atime = retry_sum[63:0];
              if (item.sink_accepts) begin
                s.armed     = 1'b1;
                s.drv_state = pws_pkg::ST_ARMED;
                status      = pws_pkg::EV_WAITING;
                dv          = 1'b1;
                due         = retry_sum[63:0];
              end else begin
                fatal = 1'b1;
              end
            end
          end else if (item.pump_code == pws_pkg::PC_END) begin
            shut       = 1'b1;
            shut_state = pws_pkg::ST_ENDED;
            status     = pws_pkg::EV_ENDED;
          end else begin
            fatal = 1'b1;
            if (item.pump_code > pws_pkg::PC_FATAL_LAST) begin
              echo = pws_pkg::PC_READER_FAILED;
            end
          end
        end
      end
    endcase

    if (fatal) begin
      shut       = 1'b1;
      shut_state = pws_pkg::ST_FAILED;
      status     = pws_pkg::EV_FATAL;
      dv         = 1'b0;
      due        = '0;
    end

    if (shut) begin
      s.running    = 1'b0;
      s.armed      = 1'b0;
      s.life_token = pws_pkg::advance_token(s.life_token);
      s.drv_state  = shut_state;
      disarm       = 1'b1;
    end

    state_next             = s;
    result.event_status    = status;
    result.driver_state    = s.drv_state;
    result.pump_echo_valid = ev;
    result.pump_echo       = echo;
    result.next_due_valid  = dv;
    result.next_due_ns     = due;
    result.token_out       = s.life_token;
    result.arm_kind        = kind;
    result.arm_time_ns     = atime;
    result.disarm          = disarm;
  end

endmodule
